@@ rtl/core/rle_pixel_run_expander_macros.svh @@
// assertion macros used by the run expander top level
`ifndef RLE_PIXEL_RUN_EXPANDER_MACROS_SVH
`define RLE_PIXEL_RUN_EXPANDER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define RLE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rle expander check failed");

`define RLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rle expander check failed");

`else

`define RLE_ASSERT_IMPL(label, clk, rst, ante, cons)

`define RLE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/rle_pre_pkg.sv @@
`timescale 1ns / 1ps

package rle_pre_pkg;

   localparam logic [1:0] FMT_RGB565   = 2'd0;
   localparam logic [1:0] FMT_ARGB8565 = 2'd1;
   localparam logic [1:0] FMT_RGB888   = 2'd2;
   localparam logic [1:0] FMT_ARGB8888 = 2'd3;

   localparam logic CSR_IDX_PIXEL_FORMAT = 1'b0;

   // controller to datapath
   typedef struct packed {
      logic load_byte;
      logic emit_step;
   } rle_pre_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic node_done;
      logic len_nonzero;
      logic run_end;
   } rle_pre_sts_type;

   function automatic logic [2:0] fmt_byte_count(input logic [1:0] fmt);
      logic [2:0] n;
      unique case (fmt)
         FMT_RGB565:   n = 3'd2;
         FMT_ARGB8565: n = 3'd3;
         FMT_RGB888:   n = 3'd3;
         FMT_ARGB8888: n = 3'd4;
         default:      n = 3'd4;
      endcase
      return n;
   endfunction

endpackage

@@ rtl/core/rle_pre_ctrl.sv @@
`timescale 1ns / 1ps

module rle_pre_ctrl
   import rle_pre_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  rle_pre_sts_type sts,
   output rle_pre_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_GATHER = 2'b01,
      ST_EMIT   = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready     = (state_ff == ST_GATHER);
   assign rsp_valid     = (state_ff == ST_EMIT);
   assign cmd.load_byte = req_valid & req_ready;
   assign cmd.emit_step = rsp_valid & rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_GATHER: begin
            // zero length nodes are swallowed without a word
            if (cmd.load_byte && sts.node_done && sts.len_nonzero) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cmd.emit_step && sts.run_end) begin
               state_in = ST_GATHER;
            end
         end
         default: state_in = ST_GATHER;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_GATHER;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/rle_pre_dp.sv @@
`timescale 1ns / 1ps

module rle_pre_dp
   import rle_pre_pkg::*;
#(
   parameter int PIXEL_LANES = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  rle_pre_cmd_type cmd,
   output rle_pre_sts_type sts,
   input  logic [7:0]      req_stream_byte,
   input  logic            cfg_we,
   input  logic [1:0]      cfg_wdata,
   output logic [1:0]      pixel_format,
   output logic [31:0]     rsp_pixel_lane0,
   output logic [31:0]     rsp_pixel_lane1,
   output logic [31:0]     rsp_pixel_lane2,
   output logic [31:0]     rsp_pixel_lane3,
   output logic [2:0]      rsp_lanes_valid,
   output logic            rsp_run_last
);

   localparam logic [7:0] LANES_B = 8'(PIXEL_LANES);

   logic [2:0]  byte_idx_ff, byte_idx_in;
   logic [7:0]  run_len_ff, run_len_in;
   logic [31:0] acc_ff, acc_in;
   logic [1:0]  fmt_ff;
   logic [1:0]  pos;
   logic [7:0]  group;

   assign pos          = 2'(byte_idx_ff - 3'd1);
   assign group        = sts.run_end ? run_len_ff : LANES_B;
   assign pixel_format = fmt_ff;

   // node completes once the byte count of the current format is reached
   assign sts.node_done   = (byte_idx_ff != 3'd0) && (byte_idx_ff >= fmt_byte_count(fmt_ff));
   assign sts.len_nonzero = (run_len_ff != 8'd0);
   assign sts.run_end     = (run_len_ff <= LANES_B);

   assign rsp_pixel_lane0 = (group > 8'd0) ? acc_ff : 32'd0;
   assign rsp_pixel_lane1 = (group > 8'd1) ? acc_ff : 32'd0;
   assign rsp_pixel_lane2 = (group > 8'd2) ? acc_ff : 32'd0;
   assign rsp_pixel_lane3 = (group > 8'd3) ? acc_ff : 32'd0;
   assign rsp_lanes_valid = group[2:0];
   assign rsp_run_last    = sts.run_end;

   always_comb begin
      byte_idx_in = byte_idx_ff;
      run_len_in  = run_len_ff;
      acc_in      = acc_ff;
      if (cmd.load_byte) begin
         if (byte_idx_ff == 3'd0) begin
            run_len_in  = req_stream_byte;
            acc_in      = 32'd0;
            byte_idx_in = 3'd1;
         end else begin
            acc_in      = acc_ff | (32'(req_stream_byte) << {pos, 3'b000});
            byte_idx_in = sts.node_done ? 3'd0 : byte_idx_ff + 3'd1;
         end
      end else if (cmd.emit_step) begin
         run_len_in = run_len_ff - group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_idx_ff <= 3'd0;
         run_len_ff  <= 8'd0;
         acc_ff      <= 32'd0;
         fmt_ff      <= FMT_RGB565;
      end else begin
         byte_idx_ff <= byte_idx_in;
         run_len_ff  <= run_len_in;
         acc_ff      <= acc_in;
         if (cfg_we) begin
            fmt_ff <= cfg_wdata;
         end
      end
   end

endmodule

@@ rtl/core/rle_pixel_run_expander.sv @@
`timescale 1ns / 1ps
`include "rle_pixel_run_expander_macros.svh"

// Run-length pixel expander: takes a node stream one byte per word, each node a
// length byte then 2, 3, 3 or 4 pixel bytes (least significant first) as set by
// pixel_format at byte address 0 (0 rgb565, 1 argb8565, 2 rgb888, 3 argb8888).
// Bytes are taken at one per cycle while a node gathers. When the last pixel
// byte arrives the controller stops taking bytes and sends the pixel in groups
// of PIXEL_LANES, one word per cycle as the sink accepts; the controller holds
// off the input while a run goes out. A zero length sends nothing. Unused
// lanes read zero; lanes_valid is the group size taken modulo 8.

module rle_pixel_run_expander
   import rle_pre_pkg::*;
#(
   parameter int PIXEL_LANES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_pixel_lane0,
   output logic [31:0] rsp_pixel_lane1,
   output logic [31:0] rsp_pixel_lane2,
   output logic [31:0] rsp_pixel_lane3,
   output logic [2:0]  rsp_lanes_valid,
   output logic        rsp_run_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   rle_pre_cmd_type cmd;
   rle_pre_sts_type sts;
   logic            cfg_we;
   logic [1:0]      pixel_format;

   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel & csr_penable & csr_pwrite & csr_pready
                       & (csr_paddr[2] == CSR_IDX_PIXEL_FORMAT);
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_PIXEL_FORMAT)
                       ? {30'd0, pixel_format} : 32'd0;

   rle_pre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rle_pre_dp #(
      .PIXEL_LANES (PIXEL_LANES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_stream_byte (req_stream_byte),
      .cfg_we          (cfg_we),
      .cfg_wdata       (csr_pwdata[1:0]),
      .pixel_format    (pixel_format),
      .rsp_pixel_lane0 (rsp_pixel_lane0),
      .rsp_pixel_lane1 (rsp_pixel_lane1),
      .rsp_pixel_lane2 (rsp_pixel_lane2),
      .rsp_pixel_lane3 (rsp_pixel_lane3),
      .rsp_lanes_valid (rsp_lanes_valid),
      .rsp_run_last    (rsp_run_last)
   );

   // no byte taken while a run is going out
   `RLE_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   // a run keeps sending until its flagged word
   `RLE_ASSERT_NEXT(a_run_continues, clock, reset,
      rsp_valid && rsp_ready && !rsp_run_last, rsp_valid)
   // after the flagged word the block goes back to taking bytes
   `RLE_ASSERT_NEXT(a_run_ends, clock, reset,
      rsp_valid && rsp_ready && rsp_run_last, !rsp_valid && req_ready)

endmodule

@@ tb/rle_pixel_run_expander_tb.sv @@
`timescale 1ns / 1ps

module rle_pixel_run_expander_tb;
   import rle_pre_pkg::*;

   localparam int LANES = 4;
   localparam logic [2:0] FORMAT_ADDR = {CSR_IDX_PIXEL_FORMAT, 2'b00};
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AFTER_BYTES = 150;

   typedef struct packed {
      logic [3:0][31:0] lane;
      logic [2:0]       count;
      logic             last;
   } pixel_group_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_stream_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_pixel_lane0;
   logic [31:0] rsp_pixel_lane1;
   logic [31:0] rsp_pixel_lane2;
   logic [31:0] rsp_pixel_lane3;
   logic [2:0]  rsp_lanes_valid;
   logic        rsp_run_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rle_pixel_run_expander dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stream_byte (req_stream_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_lane0 (rsp_pixel_lane0),
      .rsp_pixel_lane1 (rsp_pixel_lane1),
      .rsp_pixel_lane2 (rsp_pixel_lane2),
      .rsp_pixel_lane3 (rsp_pixel_lane3),
      .rsp_lanes_valid (rsp_lanes_valid),
      .rsp_run_last    (rsp_run_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // stream bytes waiting to be offered, pixel groups waiting to come out
   logic [7:0]      byte_queue [$];
   pixel_group_type pending_groups [$];

   // expander state as the testbench sees it
   logic [1:0]  pixel_format_now = FMT_RGB565;
   logic [2:0]  node_pos = 3'd0;
   logic [7:0]  node_len = 8'd0;
   logic [31:0] node_pixel = 32'd0;

   int unsigned mismatches = 0;
   int unsigned bytes_taken = 0;
   bit          calm = 1'b0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("rle_pixel_run_expander_tb: errors");
      $finish;
   end

   function automatic int unsigned format_byte_count(input logic [1:0] fmt);
      unique case (fmt)
         FMT_RGB565:   return 2;
         FMT_ARGB8565: return 3;
         FMT_RGB888:   return 3;
         default:      return 4;
      endcase
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] wanted);
      $display("mismatch %s: got %h wanted %h", what, got, wanted);
      mismatches++;
   endtask

   // one stream byte into the node assembler, runs expanded into groups of four
   task automatic take_node_byte(input logic [7:0] b);
      int unsigned pos;
      int unsigned left;
      int unsigned grp;
      pixel_group_type g;
      if (node_pos == 3'd0) begin
         node_len = b;
         node_pixel = 32'd0;
         node_pos = 3'd1;
      end else begin
         pos = node_pos - 1;
         if (pos < 4)
            node_pixel = node_pixel | (32'(b) << (8 * pos));
         node_pos = node_pos + 3'd1;
         if (pos + 1 >= format_byte_count(pixel_format_now)) begin
            node_pos = 3'd0;
            left = node_len;
            while (left > 0) begin
               grp = (left < LANES) ? left : LANES;
               for (int i = 0; i < 4; i++)
                  g.lane[i] = (i < grp) ? node_pixel : 32'd0;
               left = left - grp;
               g.count = 3'(grp);
               g.last = (left == 0);
               pending_groups.push_back(g);
            end
         end
      end
   endtask

   task automatic queue_node(input logic [7:0] len, input logic [31:0] pixel);
      byte_queue.push_back(len);
      for (int i = 0; i < format_byte_count(pixel_format_now); i++)
         byte_queue.push_back(pixel[8 * i +: 8]);
   endtask

   task automatic queue_random_nodes(input int unsigned target);
      int unsigned pushed;
      int unsigned pick;
      logic [7:0] len;
      pushed = 0;
      while (pushed < target) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)
            len = 8'd0;
         else if (pick <= 12)
            len = 8'($urandom_range(1, 12));
         else if (pick <= 17)
            len = 8'($urandom_range(13, 64));
         else
            len = 8'($urandom_range(65, 255));
         queue_node(len, $urandom);
         pushed = pushed + 1 + format_byte_count(pixel_format_now);
      end
   endtask

   // waits for every byte to be taken and every group to come out, then lets
   // a partial node settle
   task automatic wait_drained();
      do @(negedge clock);
      while (byte_queue.size() != 0 || req_valid || pending_groups.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_pixel_format(input logic [1:0] fmt);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= FORMAT_ADDR;
      csr_pwdata <= {30'd0, fmt};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      pixel_format_now = fmt;
      // straight into a read back
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      if (csr_prdata !== {30'd0, fmt})
         flag_mismatch("pixel_format read back", csr_prdata, {30'd0, fmt});
      do @(posedge clock);
      while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // sender: random idle gaps between words unless calm is set
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (byte_queue.size() != 0 && !calm && $urandom_range(0, 9) == 0) begin
            req_valid <= 1'b0;
            gap_left <= $urandom_range(0, 4);
         end else if (byte_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_stream_byte <= byte_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // one long hold-off of the sink while the stream keeps coming
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && bytes_taken >= HOLD_AFTER_BYTES) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // prediction first, so a group caused at this edge is already queued
   always @(posedge clock) begin : monitor
      pixel_group_type wanted;
      logic [3:0][31:0] lanes_seen;
      if (!reset) begin
         if (req_valid && req_ready) begin
            take_node_byte(req_stream_byte);
            bytes_taken <= bytes_taken + 1;
         end
         if (rsp_valid && rsp_ready) begin
            lanes_seen = {rsp_pixel_lane3, rsp_pixel_lane2, rsp_pixel_lane1, rsp_pixel_lane0};
            if (pending_groups.size() == 0) begin
               flag_mismatch("word with nothing pending", lanes_seen[0], 32'd0);
            end else begin
               wanted = pending_groups.pop_front();
               for (int i = 0; i < 4; i++)
                  if (lanes_seen[i] !== wanted.lane[i])
                     flag_mismatch($sformatf("pixel_lane%0d", i), lanes_seen[i],
                                   wanted.lane[i]);
               if (rsp_lanes_valid !== wanted.count)
                  flag_mismatch("lanes_valid", 32'(rsp_lanes_valid), 32'(wanted.count));
               if (rsp_run_last !== wanted.last)
                  flag_mismatch("run_last", 32'(rsp_run_last), 32'(wanted.last));
            end
         end
      end
   end

   initial begin : stimulus
      logic [1:0] fmt_plan [6];
      int unsigned tail_k;
      int unsigned nc;
      fmt_plan = '{FMT_ARGB8888, FMT_RGB565, FMT_RGB888, FMT_ARGB8565,
                   FMT_ARGB8888, FMT_RGB565};
      tail_k = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // format out of reset: zero length, single pixel, one full group plus one
      queue_node(8'd0, 32'h0000_0000);
      queue_node(8'd1, 32'h0000_ffff);
      queue_node(8'd5, 32'h0000_5aa5);
      wait_drained();
      // longest run at the widest pixel
      set_pixel_format(FMT_ARGB8888);
      queue_node(8'd255, 32'hffff_ffff);
      wait_drained();
      set_pixel_format(FMT_ARGB8565);
      queue_node(8'd4, 32'h00c3_a17e);
      wait_drained();
      set_pixel_format(FMT_RGB888);
      queue_node(8'd7, 32'h0000_0000);
      wait_drained();
      // format narrowed while a node is half gathered
      set_pixel_format(FMT_ARGB8888);
      byte_queue.push_back(8'd6);
      byte_queue.push_back(8'h11);
      byte_queue.push_back(8'h22);
      wait_drained();
      set_pixel_format(FMT_RGB565);
      byte_queue.push_back(8'h33);

      for (int p = 0; p < 6; p++) begin
         wait_drained();
         set_pixel_format(fmt_plan[p]);
         if (tail_k != 0) begin
            nc = format_byte_count(fmt_plan[p]);
            repeat ((tail_k >= nc) ? 1 : nc - tail_k)
               byte_queue.push_back(8'($urandom));
            tail_k = 0;
         end
         if (p == 5)
            calm = 1'b1;
         queue_random_nodes(40);
         // leave a node unfinished across the next format change
         if (p < 5 && $urandom_range(0, 1) == 1) begin
            tail_k = $urandom_range(1, format_byte_count(fmt_plan[p]) - 1);
            byte_queue.push_back(8'($urandom_range(1, 20)));
            repeat (tail_k)
               byte_queue.push_back(8'($urandom));
         end
      end
      wait_drained();
      repeat (20) @(negedge clock);
      if (mismatches == 0)
         $display("rle_pixel_run_expander_tb: clean");
      else
         $display("rle_pixel_run_expander_tb: errors");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/rle_pre_pkg.sv
rtl/core/rle_pre_ctrl.sv
rtl/core/rle_pre_dp.sv
rtl/core/rle_pixel_run_expander.sv
tb/rle_pixel_run_expander_tb.sv
